FILE: rtl/tse_pkg.sv
// ----------------------------------------------------------------------------
// tse_pkg
// Shared types and constants of the fixed-point exp series evaluator.
// ----------------------------------------------------------------------------
package tse_pkg;

  localparam int ARG_W         = 20;  // x_value, signed
  localparam int RES_W         = 36;  // exp_value, signed Q12.24
  localparam int SUM_FRAC_BITS = 24;
  localparam int TERM_W        = 39;  // term magnitude, up to the cap
  localparam int RECIP_W       = 25;  // unsigned Q.24 reciprocal
  localparam int MUL_A_W       = 20;  // one slice of a term operand
  localparam int MUL_B_W       = 25;
  localparam int PROD_W        = MUL_A_W + MUL_B_W;
  localparam int ACC_W         = 64;
  localparam int SUM_W         = 45;  // holds 1.0 plus 63 capped terms

  localparam int TC_W  = 5;
  localparam int THR_W = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_TERM_COUNT     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EARLY_STOP_ON  = 2'd2;

  localparam logic [TERM_W-1:0] TERM_CAP = TERM_W'(64'd1 << 38);
  localparam logic [TERM_W-1:0] TERM_ONE = TERM_W'(64'd1 << SUM_FRAC_BITS);
  localparam logic signed [SUM_W-1:0] OUT_MAX = SUM_W'((64'd1 << (RES_W - 1)) - 64'd1);
  localparam logic signed [SUM_W-1:0] OUT_MIN = ~OUT_MAX;

  typedef enum logic [3:0] {
    S_IDLE,
    S_M1L,
    S_M1H,
    S_P,
    S_M2L,
    S_M2H,
    S_T,
    S_ADD,
    S_FIN
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_M1L,
    OP_M1H,
    OP_P,
    OP_M2L,
    OP_M2H,
    OP_T,
    OP_ADD,
    OP_FIN
  } op_t;

  typedef struct packed {
    op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic stop_hit;
  } dp_status_t;

endpackage

FILE: rtl/tse_datapath.sv
// ----------------------------------------------------------------------------
// tse_datapath
// Term and sum registers, shared 20x25 multiplier, reciprocal table,
// clamping and the result register.
// ----------------------------------------------------------------------------
module tse_datapath
  import tse_pkg::*;
#(
  parameter int MAX_TERMS     = 32,
  parameter int ARG_FRAC_BITS = 16,
  parameter int IDX_W         = $clog2(MAX_TERMS)
) (
  input  logic                    clk,
  input  logic signed [ARG_W-1:0] x_value,
  input  logic [THR_W-1:0]        stop_threshold,
  input  logic                    early_stop_on,
  input  dp_cmd_t                 cmd,
  input  logic [IDX_W-1:0]        idx,
  output dp_status_t              status,
  output logic signed [RES_W-1:0] exp_value,
  output logic                    saturated
);

  localparam logic [ACC_W-1:0] RND_ARG  = ACC_W'(64'd1 << (ARG_FRAC_BITS - 1));
  localparam logic [ACC_W-1:0] RND_TERM = ACC_W'(64'd1 << (SUM_FRAC_BITS - 1));

  logic [RECIP_W-1:0] recip_rom [MAX_TERMS];

  for (genvar g = 0; g < MAX_TERMS; g++) begin : g_recip
    localparam int unsigned Div = (g == 0) ? 1 : g;
    localparam logic [RECIP_W-1:0] Word = (g == 0) ? '0 :
      RECIP_W'((((64'd1 << (SUM_FRAC_BITS + 1)) / Div) + 64'd1) >> 1);
    assign recip_rom[g] = Word;
  end

  logic [ARG_W-1:0]      xmag;
  logic                  xneg;
  logic [TERM_W-1:0]     tmag;
  logic                  tneg;
  logic [TERM_W-1:0]     pval;
  logic [ACC_W-1:0]      acc;
  logic signed [SUM_W-1:0] sum;
  logic                  sat;

  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [PROD_W-1:0]  prod;
  logic [ACC_W-1:0]   shifted;
  logic               over;
  logic [TERM_W-1:0]  clamped;
  logic signed [SUM_W-1:0] tsigned;

  // operand select for the shared multiplier, low slice then high slice
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_M1L: begin
        mul_a = tmag[MUL_A_W-1:0];
        mul_b = MUL_B_W'(xmag);
      end
      OP_M1H: begin
        mul_a = MUL_A_W'(tmag[TERM_W-1:MUL_A_W]);
        mul_b = MUL_B_W'(xmag);
      end
      OP_M2L: begin
        mul_a = pval[MUL_A_W-1:0];
        mul_b = recip_rom[idx];
      end
      OP_M2H: begin
        mul_a = MUL_A_W'(pval[TERM_W-1:MUL_A_W]);
        mul_b = recip_rom[idx];
      end
      default: ;
    endcase
  end

  assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

  assign shifted = (cmd.op == OP_P) ? (acc >> ARG_FRAC_BITS) : (acc >> SUM_FRAC_BITS);
  assign over    = shifted > ACC_W'(TERM_CAP);
  assign clamped = over ? TERM_CAP : shifted[TERM_W-1:0];
  assign tsigned = $signed(SUM_W'(tmag));

  assign status.stop_hit = early_stop_on && (tmag <= TERM_W'(stop_threshold));

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        xneg <= x_value[ARG_W-1];
        xmag <= x_value[ARG_W-1] ? (~x_value + ARG_W'(1)) : x_value;
        tmag <= TERM_ONE;
        tneg <= 1'b0;
        sum  <= $signed(SUM_W'(TERM_ONE));
        sat  <= 1'b0;
      end
      OP_M1L: acc <= ACC_W'(prod) + RND_ARG;
      OP_M1H: acc <= acc + (ACC_W'(prod) << MUL_A_W);
      OP_P: begin
        pval <= clamped;
        if (over) begin
          sat <= 1'b1;
        end
      end
      OP_M2L: acc <= ACC_W'(prod) + RND_TERM;
      OP_M2H: acc <= acc + (ACC_W'(prod) << MUL_A_W);
      OP_T: begin
        tmag <= clamped;
        tneg <= tneg ^ xneg;
        if (over) begin
          sat <= 1'b1;
        end
      end
      OP_ADD: sum <= tneg ? (sum - tsigned) : (sum + tsigned);
      OP_FIN: begin
        if (sum > OUT_MAX) begin
          exp_value <= OUT_MAX[RES_W-1:0];
          saturated <= 1'b1;
        end else if (sum < OUT_MIN) begin
          exp_value <= OUT_MIN[RES_W-1:0];
          saturated <= 1'b1;
        end else begin
          exp_value <= sum[RES_W-1:0];
          saturated <= sat;
        end
      end
      default: ;
    endcase
  end

endmodule

FILE: rtl/tse_ctrl.sv
// ----------------------------------------------------------------------------
// tse_ctrl
// Sequencer: steps each term through two split multiplies, clamp and
// accumulate, counts terms and hands the result to the output register.
// ----------------------------------------------------------------------------
module tse_ctrl
  import tse_pkg::*;
#(
  parameter int MAX_TERMS = 32,
  parameter int IDX_W     = $clog2(MAX_TERMS)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             arg_valid,
  output logic             arg_stall,
  output logic             res_valid,
  input  logic             res_stall,
  input  logic [TC_W-1:0]  term_count,
  output dp_cmd_t          cmd,
  output logic [IDX_W-1:0] idx,
  input  dp_status_t       status
);

  localparam int NW = (IDX_W > TC_W) ? IDX_W : TC_W;
  localparam logic [NW-1:0] LIMIT = NW'(MAX_TERMS - 1);

  state_t           state, state_next;
  logic [IDX_W-1:0] idx_next;
  logic             res_valid_next;
  logic [NW-1:0]    n_full;
  logic [IDX_W-1:0] n_terms;

  assign n_full  = NW'(term_count);
  assign n_terms = (n_full > LIMIT) ? LIMIT[IDX_W-1:0] : n_full[IDX_W-1:0];

  assign arg_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      idx       <= '0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      idx       <= idx_next;
      res_valid <= res_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    idx_next       = idx;
    res_valid_next = res_valid && res_stall;
    cmd.op         = OP_NONE;
    unique case (state)
      S_IDLE: begin
        if (arg_valid) begin
          cmd.op     = OP_LOAD;
          idx_next   = IDX_W'(1);
          state_next = (n_terms == '0) ? S_FIN : S_M1L;
        end
      end
      S_M1L: begin
        cmd.op     = OP_M1L;
        state_next = S_M1H;
      end
      S_M1H: begin
        cmd.op     = OP_M1H;
        state_next = S_P;
      end
      S_P: begin
        cmd.op     = OP_P;
        state_next = S_M2L;
      end
      S_M2L: begin
        cmd.op     = OP_M2L;
        state_next = S_M2H;
      end
      S_M2H: begin
        cmd.op     = OP_M2H;
        state_next = S_T;
      end
      S_T: begin
        cmd.op     = OP_T;
        state_next = S_ADD;
      end
      S_ADD: begin
        cmd.op = OP_ADD;
        // stop test uses the fresh term magnitude
        if (status.stop_hit || (idx == n_terms)) begin
          state_next = S_FIN;
        end else begin
          idx_next   = idx + IDX_W'(1);
          state_next = S_M1L;
        end
      end
      S_FIN: begin
        // wait until the output register is free
        if (!res_valid || !res_stall) begin
          cmd.op         = OP_FIN;
          res_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

FILE: rtl/taylor_exp_evaluator.sv
// ----------------------------------------------------------------------------
// taylor_exp_evaluator
// exp(x) as a truncated Taylor series in fixed point, saturating output.
// ----------------------------------------------------------------------------
// One item at a time. An item with n summed terms (n = term_count limited to
// MAX_TERMS-1, or fewer when the early stop fires) has its result registered
// in a final step after its last term, and no new item is accepted until that
// step is done. Each term runs two 39-bit by 20/25-bit multiplies as two
// slices each on one shared 20x25 multiplier, plus a clamp step after each
// multiply and one accumulate step. The reset term_count is 11. The result
// sits in an output register, so the next item is taken while it waits.
module taylor_exp_evaluator
  import tse_pkg::*;
#(
  parameter int MAX_TERMS     = 32,
  parameter int ARG_FRAC_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    arg_valid,
  output logic                    arg_stall,
  input  logic signed [ARG_W-1:0] x_value,
  output logic                    res_valid,
  input  logic                    res_stall,
  output logic signed [RES_W-1:0] exp_value,
  output logic                    saturated,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data
);

  localparam int IDX_W = $clog2(MAX_TERMS);

  logic [TC_W-1:0]  term_count;
  logic [THR_W-1:0] stop_threshold;
  logic             early_stop_on;

  dp_cmd_t          cmd;
  dp_status_t       status;
  logic [IDX_W-1:0] idx;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      term_count     <= TC_W'(11);
      stop_threshold <= THR_W'(17);
      early_stop_on  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_TERM_COUNT:     term_count     <= cfg_data[TC_W-1:0];
        REG_STOP_THRESHOLD: stop_threshold <= cfg_data[THR_W-1:0];
        REG_EARLY_STOP_ON:  early_stop_on  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  tse_ctrl #(
    .MAX_TERMS(MAX_TERMS),
    .IDX_W    (IDX_W)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .arg_valid (arg_valid),
    .arg_stall (arg_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .term_count(term_count),
    .cmd       (cmd),
    .idx       (idx),
    .status    (status)
  );

  tse_datapath #(
    .MAX_TERMS    (MAX_TERMS),
    .ARG_FRAC_BITS(ARG_FRAC_BITS),
    .IDX_W        (IDX_W)
  ) u_datapath (
    .clk           (clk),
    .x_value       (x_value),
    .stop_threshold(stop_threshold),
    .early_stop_on (early_stop_on),
    .cmd           (cmd),
    .idx           (idx),
    .status        (status),
    .exp_value     (exp_value),
    .saturated     (saturated)
  );

`ifndef SYNTH
  // an accepted item keeps the block busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (arg_valid && !arg_stall) |=> arg_stall)
    else $error("block not busy after accepting an item");

  // a new result only appears at the end of work on an item
  a_result_from_item: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(arg_stall))
    else $error("result appeared without an item in flight");

  // a stalled result is never overwritten by the next finished item
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_stall) |=> (res_valid && $stable(exp_value)
                                  && $stable(saturated)))
    else $error("waiting result was overwritten");
`endif

endmodule
